/* rtl/crcfr_pkg.sv */
// shared types, constants and the byte-wide crc-16/ccitt-false update
// for the channel frame receiver; no dependencies
package crcfr_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CHANNEL_RESET = 16'd6;
    localparam logic [2:0]  FRAME_LEN     = 3'd6;
    localparam logic [2:0]  POS_SAT       = 3'd7;
    localparam logic [2:0]  POS_CRC_END   = 3'd4;
    localparam logic [2:0]  POS_CHAN_LO   = 3'd2;
    localparam logic [2:0]  POS_CHAN_HI   = 3'd3;
    localparam logic [2:0]  POS_CRC_LO    = 3'd4;
    localparam logic [2:0]  POS_CRC_HI    = 3'd5;

    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
    localparam logic [1:0] ST_BAD_CRC    = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] current_channel;
        logic        channel_changed;
    } out_item_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'd0, x[7:4]};
        return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
    endfunction

endpackage

/* rtl/crcfr_frame_core.sv */
// frame state, crc accumulation and frame decision for one byte per step
// depends on crcfr_pkg
module crcfr_frame_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  crcfr_pkg::in_item_t item,
    output crcfr_pkg::out_item_t result
);

    logic [15:0] crc_reg;
    logic [2:0]  pos_reg;
    logic [15:0] chan_reg;
    logic [15:0] rcrc_reg;
    logic [15:0] stored_reg;

    logic [15:0] crc_next;
    logic [2:0]  pos_next;
    logic [15:0] chan_next;
    logic [15:0] rcrc_next;
    logic [15:0] stored_next;
    logic [1:0]  status;
    logic        changed;

    always_comb begin
        crc_next  = (pos_reg < crcfr_pkg::POS_CRC_END)
                  ? crcfr_pkg::crc_byte(crc_reg, item.data_byte)
                  : crc_reg;
        chan_next = chan_reg;
        rcrc_next = rcrc_reg;
        case (pos_reg)
            crcfr_pkg::POS_CHAN_LO: chan_next = {chan_reg[15:8], item.data_byte};
            crcfr_pkg::POS_CHAN_HI: chan_next = {item.data_byte, chan_reg[7:0]};
            crcfr_pkg::POS_CRC_LO:  rcrc_next = {rcrc_reg[15:8], item.data_byte};
            crcfr_pkg::POS_CRC_HI:  rcrc_next = {item.data_byte, rcrc_reg[7:0]};
            default: ;
        endcase
        pos_next = (pos_reg == crcfr_pkg::POS_SAT) ? pos_reg : pos_reg + 3'd1;

        changed = 1'b0;
        if (pos_next != crcfr_pkg::FRAME_LEN) begin
            status = crcfr_pkg::ST_BAD_LENGTH;
        end else if (crc_next != rcrc_next) begin
            status = crcfr_pkg::ST_BAD_CRC;
        end else begin
            status  = crcfr_pkg::ST_ACCEPTED;
            changed = (stored_reg != chan_next);
        end
        stored_next = changed ? chan_next : stored_reg;

        result.frame_status    = status;
        result.current_channel = stored_next;
        result.channel_changed = changed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= crcfr_pkg::CRC_INIT;
            pos_reg    <= 3'd0;
            chan_reg   <= 16'd0;
            rcrc_reg   <= 16'd0;
            stored_reg <= crcfr_pkg::CHANNEL_RESET;
        end else if (step) begin
            if (item.last_byte) begin
                crc_reg    <= crcfr_pkg::CRC_INIT;
                pos_reg    <= 3'd0;
                chan_reg   <= 16'd0;
                rcrc_reg   <= 16'd0;
                stored_reg <= stored_next;
            end else begin
                crc_reg  <= crc_next;
                pos_reg  <= pos_next;
                chan_reg <= chan_next;
                rcrc_reg <= rcrc_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.last_byte |=> pos_reg == 3'd0 && crc_reg == crcfr_pkg::CRC_INIT)
        else $error("frame state not cleared after last byte");
    a_stored_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(stored_reg) |-> $past(step && item.last_byte))
        else $error("stored channel changed outside a frame end");
    a_changed_means_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        result.channel_changed |-> result.frame_status == crcfr_pkg::ST_ACCEPTED)
        else $error("channel changed on a rejected frame");
    a_short_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < crcfr_pkg::POS_CRC_HI |-> result.frame_status == crcfr_pkg::ST_BAD_LENGTH)
        else $error("short frame not reported as wrong length");
`endif

endmodule

/* rtl/crc16_channel_frame_receiver.sv */
// channel-set frame receiver with crc-16/ccitt-false check, top level
// depends on crcfr_pkg and crcfr_frame_core
//
// usage:
//   s_ channel: one frame byte per transaction (s_data.data_byte) with
//   s_data.last_byte marking the final byte of a frame.
//   m_ channel: one transaction per frame, issued for its final byte, with
//   frame_status (accepted, wrong length, crc mismatch), the stored channel
//   after the frame and a flag set when an accepted frame changed it.
//   a valid frame is six bytes: id, channel, crc, each low byte first; the
//   crc covers the first four bytes.
// throughput: one byte per cycle, sustained, while m_ready is high.
// path: a final byte passes one input register, then the crc update and
//   frame decision feed the result register, which drives m_valid.
// stall: while a result waits on m_ready, non-final bytes keep flowing;
//   a final byte holds in the input register until the result register
//   frees, and s_ready drops behind it.
// reset: aresetn, synchronous, active low; clears the frame state, empties
//   both registers and sets the stored channel to 6.
module crc16_channel_frame_receiver (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  crcfr_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output crcfr_pkg::out_item_t m_data
);

    logic                 in_valid_reg;
    crcfr_pkg::in_item_t  in_item_reg;
    logic                 m_valid_reg;
    crcfr_pkg::out_item_t m_data_reg;

    logic                 out_free;
    logic                 step;
    crcfr_pkg::out_item_t result;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || step;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    crcfr_frame_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && in_item_reg.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_item_reg.last_byte) begin
            m_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(step && in_item_reg.last_byte))
        else $error("result overwritten while stalled");
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.frame_status != 2'd3)
        else $error("illegal frame status");
    a_last_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_item_reg.last_byte && !out_free |-> !s_ready)
        else $error("input taken while final byte blocked");
`endif

endmodule
